// ===== src/wmbb_pkg.sv =====
// Package for the warp map bilinear blend unit: widths, register indexes,
// status codes and fixed-point constants. No dependencies.
package wmbb_pkg;

   localparam int DEF_MAX_SECOND_WIDTH  = 256;
   localparam int DEF_MAX_SECOND_HEIGHT = 256;
   localparam int DEF_FRAC_BITS         = 16;

   localparam int STORE_AW   = 16;
   localparam int POS_FRAC   = 15;
   localparam int TOL_LOW    = 33;
   localparam int TOL_HIGH   = 32735;
   localparam int VEC_W      = 32;
   localparam int CONF_W     = 18;
   localparam int ENTRY_W    = 2 * VEC_W + CONF_W;

   localparam logic [2:0] REG_LEVEL_FIRST  = 3'd0;
   localparam logic [2:0] REG_LEVEL_SECOND = 3'd1;
   localparam logic [2:0] REG_ORIGIN_X     = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd3;
   localparam logic [2:0] REG_WIDTH        = 3'd4;
   localparam logic [2:0] REG_HEIGHT       = 3'd5;
   localparam logic [2:0] REG_BLEND_WEIGHT = 3'd6;
   localparam logic [2:0] REG_CONF_THRESH  = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_NEG     = 2'd2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_BLEND = 1'b1;

   typedef struct packed {
      logic [3:0]         level_first;
      logic [3:0]         level_second;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [8:0]         width;
      logic [8:0]         height;
      logic [16:0]        blend_weight;
      logic [16:0]        conf_thresh;
   } cfg_type;

   // round half up shift of a signed 80-bit value
   function automatic logic signed [79:0] round_shr80(input logic signed [79:0] v,
                                                      input logic [4:0] s);
      logic signed [79:0] b;
      begin
         b = (s == 5'd0) ? 80'sd0 : (80'sd1 <<< (s - 5'd1));
         round_shr80 = (v + b) >>> s;
      end
   endfunction

endpackage

// ===== src/wmbb_blend.sv =====
// Blend of one sampled vector component with the item's own component.
// Three register stages: products, level scaling, final rounding and saturation.
// Depends on wmbb_pkg.
module wmbb_blend (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  own,
   input  logic signed [47:0]  sampled,
   input  logic [16:0]         wb,
   input  logic [3:0]          l1,
   input  logic [3:0]          l2,
   output logic signed [31:0]  result
);
   import wmbb_pkg::*;

   logic signed [79:0] t1_ff, t1_in, t2_ff, t2_in;
   logic signed [79:0] sum_ff, sum_in;
   logic signed [31:0] result_ff, result_in;
   logic [3:0]         l1_ff, l2_ff;
   logic signed [79:0] lim, sat, r;
   logic [3:0]         d;

   always_comb begin
      t1_in = 80'(own) * $signed({1'b0, wb});
      t2_in = 80'(sampled) * $signed({1'b0, 17'(17'd65536 - wb)});
   end

   always_comb begin
      sat = 80'sd1 <<< 60;
      d   = l2_ff - l1_ff;
      lim = sat >>> d;
      if (l2_ff >= l1_ff) begin
         if (t2_ff > lim)       sum_in = t1_ff + sat;
         else if (t2_ff < -lim) sum_in = t1_ff - sat;
         else                   sum_in = t1_ff + (t2_ff <<< d);
      end else begin
         sum_in = t1_ff + round_shr80(t2_ff, 5'(l1_ff - l2_ff));
      end
   end

   always_comb begin
      r = round_shr80(sum_ff, 5'd16);
      if (r > 80'sd2147483647)       result_in = 32'sh7FFFFFFF;
      else if (r < -80'sd2147483648) result_in = 32'sh80000000;
      else                           result_in = r[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         l1_ff     <= l1;
         l2_ff     <= l2;
         sum_ff    <= sum_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ===== src/warp_map_bilinear_blend_unit.sv =====
// Warp map bilinear blend unit: second-map store, bilinear sampler, blender.
// One word per cycle sustained while rsp is not stalled.
// The whole pipeline advances together; a stalled rsp holds every stage.
// Reset (synchronous, active high) clears valid bits and the config registers to their
// reset values; the 64K-entry store is not cleared and no sweep is run.
// Depends on wmbb_pkg and wmbb_blend.
module warp_map_bilinear_blend_unit #(
   parameter int MAX_SECOND_WIDTH  = wmbb_pkg::DEF_MAX_SECOND_WIDTH,
   parameter int MAX_SECOND_HEIGHT = wmbb_pkg::DEF_MAX_SECOND_HEIGHT,
   parameter int FRAC_BITS         = wmbb_pkg::DEF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // lsb up: load_index[15:0], pos_x[31:16], pos_y[47:32], vec_x[79:48],
   // vec_y[111:80], conf[129:112], zero fill to 136
   input  logic [135:0] req_tdata,
   input  logic         req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // lsb up: out_x[31:0], out_y[63:32], out_conf[81:64], status[83:82], zero fill
   output logic [87:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_data
);
   import wmbb_pkg::*;

   localparam int NST = 10;
   localparam int WW = $clog2(MAX_SECOND_WIDTH + 1);
   localparam int HW = $clog2(MAX_SECOND_HEIGHT + 1);
   localparam int AW = FRAC_BITS + 2;
   localparam int TW = FRAC_BITS + 20;

   cfg_type cfg_ff;
   logic    adv;
   logic [NST-1:0] v_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{level_first: 4'd0, level_second: 4'd0,
                     origin_x: 16'sd0, origin_y: 16'sd0,
                     width: 9'd256, height: 9'd256,
                     blend_weight: 17'd32768, conf_thresh: 17'd0};
      end else if (csr_valid) begin
         case (csr_index)
            REG_LEVEL_FIRST:  cfg_ff.level_first  <= csr_data[3:0];
            REG_LEVEL_SECOND: cfg_ff.level_second <= csr_data[3:0];
            REG_ORIGIN_X:     cfg_ff.origin_x     <= csr_data[15:0];
            REG_ORIGIN_Y:     cfg_ff.origin_y     <= csr_data[15:0];
            REG_WIDTH:        cfg_ff.width        <= csr_data[8:0];
            REG_HEIGHT:       cfg_ff.height       <= csr_data[8:0];
            REG_BLEND_WEIGHT: cfg_ff.blend_weight <= csr_data;
            REG_CONF_THRESH:  cfg_ff.conf_thresh  <= csr_data;
            default:          cfg_ff.level_first  <= cfg_ff.level_first;
         endcase
      end
   end

   // clamped registers
   logic [WW-1:0] w_c;
   logic [HW-1:0] h_c;
   logic [16:0]   wb_c;
   always_comb begin
      if (cfg_ff.width < 9'd2) w_c = WW'(2);
      else if (32'(cfg_ff.width) > MAX_SECOND_WIDTH) w_c = WW'(MAX_SECOND_WIDTH);
      else w_c = WW'(cfg_ff.width);
      if (cfg_ff.height < 9'd2) h_c = HW'(2);
      else if (32'(cfg_ff.height) > MAX_SECOND_HEIGHT) h_c = HW'(MAX_SECOND_HEIGHT);
      else h_c = HW'(cfg_ff.height);
      wb_c = (cfg_ff.blend_weight > 17'd65536) ? 17'd65536 : cfg_ff.blend_weight;
   end

   logic [15:0]        f_idx;
   logic signed [15:0] f_px, f_py;
   logic signed [31:0] f_vx, f_vy;
   logic signed [17:0] f_c;
   assign f_idx = req_tdata[15:0];
   assign f_px  = req_tdata[31:16];
   assign f_py  = req_tdata[47:32];
   assign f_vx  = req_tdata[79:48];
   assign f_vy  = req_tdata[111:80];
   assign f_c   = req_tdata[129:112];

   logic load_go;
   assign load_go = req_tvalid && req_tuser == FUNC_LOAD;

   // load words travel to stage 3 and write the store there, in order with the reads
   logic [2:0] ld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ld_ff <= '0;
      end else if (adv) begin
         v_ff  <= {v_ff[NST-2:0], req_tvalid && req_tuser == FUNC_BLEND};
         ld_ff <= {ld_ff[1:0], load_go};
      end
   end

   // ---- stage 1: locate, position scaled to units of 2^-15
   logic signed [63:0] s1_cx, s1_cy;
   logic [14:0]        s1_fx, s1_fy;
   logic signed [31:0] s1_vx, s1_vy;
   logic signed [17:0] s1_c;
   logic [STORE_AW-1:0] s1_idx;

   function automatic logic signed [63:0] scaled(input logic signed [15:0] p,
                                                 input logic [3:0] a,
                                                 input logic [3:0] b);
      logic signed [63:0] q;
      begin
         q = 64'(p) <<< 30;
         scaled = q <<< a;
         scaled = scaled >>> (5'd15 + 5'(b));
      end
   endfunction

   logic signed [63:0] px_sc, py_sc;
   always_comb begin
      px_sc = scaled(f_px, cfg_ff.level_first, cfg_ff.level_second);
      py_sc = scaled(f_py, cfg_ff.level_first, cfg_ff.level_second);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cx  <= (px_sc >>> POS_FRAC) - 64'(cfg_ff.origin_x);
         s1_cy  <= (py_sc >>> POS_FRAC) - 64'(cfg_ff.origin_y);
         s1_fx  <= px_sc[14:0];
         s1_fy  <= py_sc[14:0];
         s1_vx  <= f_vx;
         s1_vy  <= f_vy;
         s1_c   <= f_c;
         s1_idx <= f_idx;
      end
   end

   // ---- stage 2: bounds, edge fit, weights
   logic s2_out;
   logic [WW-1:0] s2_ix;
   logic [HW-1:0] s2_iy;
   logic signed [AW-1:0] s2_ax, s2_ay;
   logic signed [31:0] s2_vx, s2_vy;
   logic signed [17:0] s2_c;
   logic [STORE_AW-1:0] s2_idx;

   function automatic logic is_out(input logic signed [63:0] i, input logic [14:0] f,
                                   input logic signed [63:0] n);
      is_out = i < -64'sd1 || (i == -64'sd1 && 32'(f) <= TOL_HIGH) ||
               (i == n - 64'sd1 && 32'(f) >= TOL_LOW) || i >= n;
   endfunction

   function automatic logic signed [AW-1:0] to_wt(input logic signed [17:0] r);
      logic signed [TW-1:0] t;
      begin
         t = TW'(r);
         if (FRAC_BITS >= POS_FRAC) t = t <<< (FRAC_BITS - POS_FRAC);
         else                       t = t >>> (POS_FRAC - FRAC_BITS);
         to_wt = AW'(t);
      end
   endfunction

   logic signed [63:0] nx, ny, ex, ey;
   logic signed [17:0] rx, ry;
   always_comb begin
      nx = 64'(w_c);
      ny = 64'(h_c);
      ex = s1_cx;
      ey = s1_cy;
      rx = 18'(s1_fx);
      ry = 18'(s1_fy);
      if (ex < 0) begin ex = 0; rx = rx - 18'sd32768; end
      else if (ex >= nx - 1) begin ex = nx - 2; rx = rx + 18'sd32768; end
      if (ey < 0) begin ey = 0; ry = ry - 18'sd32768; end
      else if (ey >= ny - 1) begin ey = ny - 2; ry = ry + 18'sd32768; end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_out <= is_out(s1_cx, s1_fx, nx) || is_out(s1_cy, s1_fy, ny);
         s2_ix  <= ex[WW-1:0];
         s2_iy  <= ey[HW-1:0];
         s2_ax  <= to_wt(rx);
         s2_ay  <= to_wt(ry);
         s2_vx  <= s1_vx;
         s2_vy  <= s1_vy;
         s2_c   <= s1_c;
         s2_idx <= s1_idx;
      end
   end

   // ---- stage 3: addresses
   logic [STORE_AW-1:0] s3_a00, s3_a10, s3_a01, s3_a11;
   logic s3_out;
   logic signed [AW-1:0] s3_ax, s3_ay;
   logic signed [31:0] s3_vx, s3_vy;
   logic signed [17:0] s3_c;
   logic [STORE_AW-1:0] s3_idx;
   logic [31:0] base;
   assign base = 32'(s2_iy) * 32'(w_c) + 32'(s2_ix);

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_a00 <= base[STORE_AW-1:0];
         s3_a10 <= STORE_AW'(base + 32'd1);
         s3_a01 <= STORE_AW'(base + 32'(w_c));
         s3_a11 <= STORE_AW'(base + 32'(w_c) + 32'd1);
         s3_out <= s2_out;
         s3_ax  <= s2_ax;
         s3_ay  <= s2_ay;
         s3_vx  <= s2_vx;
         s3_vy  <= s2_vy;
         s3_c   <= s2_c;
         s3_idx <= s2_idx;
      end
   end

   // ---- stage 4: store read, four banked copies each with one read port
   logic [ENTRY_W-1:0] mem0 [0:(1<<STORE_AW)-1];
   logic [ENTRY_W-1:0] mem1 [0:(1<<STORE_AW)-1];
   logic [ENTRY_W-1:0] mem2 [0:(1<<STORE_AW)-1];
   logic [ENTRY_W-1:0] mem3 [0:(1<<STORE_AW)-1];
   logic [ENTRY_W-1:0] wr_word;
   assign wr_word = {s3_c, s3_vy, s3_vx};

   always_ff @(posedge clock) begin
      if (adv && ld_ff[2]) begin
         mem0[s3_idx] <= wr_word;
         mem1[s3_idx] <= wr_word;
         mem2[s3_idx] <= wr_word;
         mem3[s3_idx] <= wr_word;
      end
   end

   logic [ENTRY_W-1:0] s4_e00, s4_e10, s4_e01, s4_e11;
   logic s4_out;
   logic signed [AW-1:0] s4_ax, s4_ay;
   logic signed [31:0] s4_vx, s4_vy;
   logic signed [17:0] s4_c;
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_e00 <= mem0[s3_a00];
         s4_e10 <= mem1[s3_a10];
         s4_e01 <= mem2[s3_a01];
         s4_e11 <= mem3[s3_a11];
         s4_out <= s3_out;
         s4_ax  <= s3_ax;
         s4_ay  <= s3_ay;
         s4_vx  <= s3_vx;
         s4_vy  <= s3_vy;
         s4_c   <= s3_c;
      end
   end

   // ---- stage 5: lerp along x; stage 6: lerp along y
   localparam logic signed [27:0] ONE = 28'sd1 <<< FRAC_BITS;

   function automatic logic signed [47:0] lerp(input logic signed [47:0] v0,
                                               input logic signed [47:0] v1,
                                               input logic signed [AW-1:0] a);
      logic signed [79:0] s;
      begin
         s = 80'(v0) * 80'(ONE - 28'(a)) + 80'(v1) * 80'(a);
         lerp = 48'(round_shr80(s, 5'(FRAC_BITS)));
      end
   endfunction

   logic signed [47:0] s5_x0, s5_x1, s5_y0, s5_y1;
   logic signed [17:0] s5_mc;
   logic s5_out;
   logic signed [AW-1:0] s5_ay;
   logic signed [31:0] s5_vx, s5_vy;
   logic signed [17:0] s5_c;
   logic signed [17:0] c00, c10, c01, c11, m0, m1;
   always_comb begin
      c00 = s4_e00[81:64];
      c10 = s4_e10[81:64];
      c01 = s4_e01[81:64];
      c11 = s4_e11[81:64];
      m0  = (c01 < c00) ? c01 : c00;
      m1  = (c11 < c10) ? c11 : c10;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_x0  <= lerp(48'($signed(s4_e00[31:0])), 48'($signed(s4_e10[31:0])), s4_ax);
         s5_x1  <= lerp(48'($signed(s4_e01[31:0])), 48'($signed(s4_e11[31:0])), s4_ax);
         s5_y0  <= lerp(48'($signed(s4_e00[63:32])), 48'($signed(s4_e10[63:32])), s4_ax);
         s5_y1  <= lerp(48'($signed(s4_e01[63:32])), 48'($signed(s4_e11[63:32])), s4_ax);
         s5_mc  <= (m1 < m0) ? m1 : m0;
         s5_out <= s4_out;
         s5_ay  <= s4_ay;
         s5_vx  <= s4_vx;
         s5_vy  <= s4_vy;
         s5_c   <= s4_c;
      end
   end

   logic signed [47:0] s6_rx, s6_ry;
   logic [1:0]         s6_st;
   logic signed [17:0] s6_oc;
   logic signed [31:0] s6_vx, s6_vy;
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_rx <= lerp(s5_x0, s5_x1, s5_ay);
         s6_ry <= lerp(s5_y0, s5_y1, s5_ay);
         s6_vx <= s5_vx;
         s6_vy <= s5_vy;
         if (s5_out) begin
            s6_st <= ST_OUTSIDE; s6_oc <= '0;
         end else if (s5_mc < 0) begin
            s6_st <= ST_NEG; s6_oc <= '0;
         end else begin
            s6_st <= ST_OK; s6_oc <= (s5_c < s5_mc) ? s5_c : s5_mc;
         end
      end
   end

   // ---- stages 7..9: blend
   logic signed [31:0] bx, by;
   wmbb_blend u_bx (.clock(clock), .en(adv), .own(s6_vx), .sampled(s6_rx),
                    .wb(wb_c), .l1(cfg_ff.level_first), .l2(cfg_ff.level_second),
                    .result(bx));
   wmbb_blend u_by (.clock(clock), .en(adv), .own(s6_vy), .sampled(s6_ry),
                    .wb(wb_c), .l1(cfg_ff.level_first), .l2(cfg_ff.level_second),
                    .result(by));

   logic [1:0]         d_st [0:2];
   logic signed [17:0] d_oc [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         d_st[0] <= s6_st;  d_oc[0] <= s6_oc;
         d_st[1] <= d_st[0]; d_oc[1] <= d_oc[0];
         d_st[2] <= d_st[1]; d_oc[2] <= d_oc[1];
      end
   end

   // ---- stage 10: threshold and output register
   logic signed [31:0] o_x_ff, o_y_ff;
   logic signed [17:0] o_c_ff, oc_in;
   logic [1:0]         o_st_ff;
   always_comb begin
      oc_in = d_oc[2];
      if (d_st[2] != ST_NEG && cfg_ff.conf_thresh != 17'd0 &&
          18'(d_oc[2]) >= $signed({1'b0, cfg_ff.conf_thresh}))
         oc_in = 18'sd65536;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_x_ff  <= (d_st[2] == ST_OK) ? bx : 32'sd0;
         o_y_ff  <= (d_st[2] == ST_OK) ? by : 32'sd0;
         o_c_ff  <= oc_in;
         o_st_ff <= d_st[2];
      end
   end

   assign rsp_tvalid = v_ff[NST-1];
   assign rsp_tdata  = {4'd0, o_st_ff, o_c_ff, o_y_ff, o_x_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");
   a_ready_adv: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req ready out of step with pipeline advance");
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_st_ff != ST_OK |-> o_x_ff == 32'sd0 && o_y_ff == 32'sd0)
      else $error("nonzero vector on error status");
endmodule
